/* rtl/tkl_pkg.sv */
// tkl_pkg: shared types for the top-k largest tracker
// holds the transfer payload structs and the cell control struct
// no dependencies
package tkl_pkg;

    localparam logic [4:0] LIMIT_RESET = 5'd10;

    typedef enum logic [0:0] {
        OP_OFFER = 1'b0,
        OP_READ  = 1'b1
    } tkl_op_t;

    typedef struct packed {
        tkl_op_t     operation;
        logic [15:0] key_id;
        logic [31:0] offered_size;
        logic [3:0]  read_index;
    } tkl_in_t;

    typedef struct packed {
        logic        was_inserted;
        logic [3:0]  insert_rank;
        logic [4:0]  entry_count;
        logic        entry_valid;
        logic [15:0] entry_key;
        logic [31:0] entry_size;
    } tkl_out_t;

    // per-cell control from the top level
    typedef struct packed {
        logic load_en;      // an offer transfer happens this cycle
        logic occupied;     // cell position is below the held count
        logic append_here;  // cell position equals held count and list has room
    } tkl_cell_ctl_t;

endpackage

/* rtl/tkl_cell.sv */
// tkl_cell: one rank position of the sorted list, compare-and-shift
// depends on tkl_pkg for the control struct
// takes the offer, its upper neighbor's entry, or holds
module tkl_cell #(
    parameter int KEY_WIDTH  = 16,
    parameter int SIZE_WIDTH = 32
) (
    input  logic                    aclk,
    input  tkl_pkg::tkl_cell_ctl_t  ctl,
    input  logic [KEY_WIDTH-1:0]    new_key,
    input  logic [SIZE_WIDTH-1:0]   new_size,
    input  logic                    gt_prev,
    input  logic [KEY_WIDTH-1:0]    prev_key,
    input  logic [SIZE_WIDTH-1:0]   prev_size,
    output logic                    gt,
    output logic [KEY_WIDTH-1:0]    key_out,
    output logic [SIZE_WIDTH-1:0]   size_out
);
    import tkl_pkg::*;

    logic [KEY_WIDTH-1:0]  key_reg;
    logic [SIZE_WIDTH-1:0] size_reg;

    // strictly larger keeps ties behind older entries
    assign gt       = ctl.occupied && (new_size > size_reg);
    assign key_out  = key_reg;
    assign size_out = size_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load_en) begin
            if (gt_prev) begin
                key_reg  <= prev_key;
                size_reg <= prev_size;
            end else if (gt || ctl.append_here) begin
                key_reg  <= new_key;
                size_reg <= new_size;
            end
        end
    end

endmodule

/* rtl/top_k_largest_tracker.sv */
// top_k_largest_tracker: descending list of the largest (key, size) offers
// depends on tkl_pkg and tkl_cell
// a row of compare-and-shift cells, one per rank position
//
//  channel   | ports                          | direction | payload
//  ----------+--------------------------------+-----------+-------------------
//  input     | s_valid s_ready s_data         | in        | tkl_in_t
//  result    | m_valid m_ready m_data         | out       | tkl_out_t
//  config    | cfg_valid cfg_ready cfg_data   | in        | list_limit, 5 bits
//
// on each input transfer all cells compare the offered size
// against their own entry in parallel and shift or load at the same edge
// the result lands in a single output register; a new item is taken in the
// same cycle the waiting result is transferred, so one item per cycle while m_ready is high
// reset (synchronous, active low) empties the list and sets the limit to 10
// a stall on the result side holds s_ready low until the result leaves
module top_k_largest_tracker #(
    parameter int CAPACITY   = 16,
    parameter int KEY_WIDTH  = 16,
    parameter int SIZE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tkl_pkg::tkl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tkl_pkg::tkl_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data
);
    import tkl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control state
    logic [4:0]       limit_reg;
    logic [CNT_W-1:0] held_reg;
    logic             m_valid_reg;
    tkl_out_t         m_data_reg;

    // effective limit: zero reads as one, clipped to capacity
    logic [CNT_W-1:0] lim_eff;
    logic [CNT_W-1:0] cfg_lim;
    logic             room;
    logic             s_xfer;
    logic             offer;

    // cell row wiring
    logic [CAPACITY-1:0]   gt;
    logic [CAPACITY-1:0]   gt_prev;
    logic [KEY_WIDTH-1:0]  cell_key  [CAPACITY];
    logic [SIZE_WIDTH-1:0] cell_size [CAPACITY];
    logic [KEY_WIDTH-1:0]  new_key;
    logic [SIZE_WIDTH-1:0] new_size;

    logic [CNT_W-1:0] rank;
    logic [CNT_W-1:0] held_next;
    logic             any_gt;
    logic             rd_valid;
    logic [KEY_WIDTH-1:0]  rd_key;
    logic [SIZE_WIDTH-1:0] rd_size;
    tkl_out_t         result;

    function automatic logic [CNT_W-1:0] clip_limit(input logic [4:0] lim);
        logic [CNT_W-1:0] r;
        if (lim == 5'd0) begin
            r = CNT_W'(1);
        end else if (32'(lim) > CAPACITY) begin
            r = CNT_W'(CAPACITY);
        end else begin
            r = CNT_W'(lim);
        end
        return r;
    endfunction

    assign lim_eff   = clip_limit(limit_reg);
    assign cfg_lim   = clip_limit(cfg_data);
    assign room      = held_reg < lim_eff;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign offer     = s_xfer && (s_data.operation == OP_OFFER);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign new_key  = KEY_WIDTH'(s_data.key_id);
    assign new_size = SIZE_WIDTH'(s_data.offered_size);

    // each cell shifts when its upper neighbor was beaten by the offer
    assign gt_prev = gt << 1;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        tkl_cell_ctl_t ctl;
        assign ctl.load_en     = offer;
        assign ctl.occupied    = CNT_W'(i) < held_reg;
        assign ctl.append_here = (CNT_W'(i) == held_reg) && room;

        tkl_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .SIZE_WIDTH (SIZE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_key   (new_key),
            .new_size  (new_size),
            .gt_prev   (gt_prev[i]),
            .prev_key  ((i == 0) ? new_key  : cell_key[(i == 0) ? 0 : i - 1]),
            .prev_size ((i == 0) ? new_size : cell_size[(i == 0) ? 0 : i - 1]),
            .gt        (gt[i]),
            .key_out   (cell_key[i]),
            .size_out  (cell_size[i])
        );
    end

    // insert position: first beaten cell, else the tail
    always_comb begin
        any_gt = |gt;
        rank   = held_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            if (gt[i] && !gt_prev[i]) begin
                rank = CNT_W'(i);
            end
        end
    end

    assign held_next = room ? held_reg + CNT_W'(1) : held_reg;

    // read mux over the cell row
    always_comb begin
        rd_valid = 1'b0;
        rd_key   = '0;
        rd_size  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if ((32'(s_data.read_index) == i) && (CNT_W'(i) < held_reg)) begin
                rd_valid = 1'b1;
                rd_key   = cell_key[i];
                rd_size  = cell_size[i];
            end
        end
    end

    always_comb begin
        result = '0;
        if (s_data.operation == OP_OFFER) begin
            result.was_inserted = any_gt || room;
            result.insert_rank  = (any_gt || room) ? 4'(rank) : 4'd0;
            result.entry_count  = 5'(held_next);
        end else begin
            result.entry_count  = 5'(held_reg);
            result.entry_valid  = rd_valid;
            result.entry_key    = 16'(rd_key);
            result.entry_size   = 32'(rd_size);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
                // lowering the limit drops entries past it
                if (held_reg > cfg_lim) begin
                    held_reg <= cfg_lim;
                end
            end else if (offer) begin
                held_reg <= held_next;
            end
            if (s_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= result;
        end
    end

endmodule
